### design/assert_macros.svh
// Assertion macros shared by the heading controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/ghdc_pkg.sv
// Shared types and codes for the gyro heading drive controller.
// No dependencies; imported by every module of the block.
package ghdc_pkg;

   // request codes
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_STRAIGHT = 2'd1;
   localparam logic [1:0] REQ_TURN     = 2'd2;
   localparam logic [1:0] REQ_NOP      = 2'd3;

   // drive modes
   localparam logic [1:0] MODE_STRAIGHT = 2'd0;
   localparam logic [1:0] MODE_TURN     = 2'd1;
   localparam logic [1:0] MODE_SETTLE   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_YAW_SCALE      = 3'd0;
   localparam logic [2:0] CSR_HEADING_GAIN   = 3'd1;
   localparam logic [2:0] CSR_TURN_GAIN      = 3'd2;
   localparam logic [2:0] CSR_TURN_TOLERANCE = 3'd3;
   localparam logic [2:0] CSR_TURN_TIMEOUT   = 3'd4;
   localparam logic [2:0] CSR_TURN_MIN_SPEED = 3'd5;
   localparam logic [2:0] CSR_TURN_MAX_SPEED = 3'd6;
   localparam logic [2:0] CSR_RIGHT_TRIM     = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YAW_MUL,
      ST_YAW_ADD,
      ST_ERR,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CORR,
      ST_UPDATE,
      ST_COMMAND,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul_yaw;
      logic acc_yaw;
      logic calc_err;
      logic mul_lo;
      logic mul_hi;
      logic calc_corr;
      logic update;
      logic apply_cmd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [15:0] yaw_scale;
      logic [11:0] heading_gain;
      logic [11:0] turn_gain;
      logic [11:0] turn_tolerance;
      logic [15:0] turn_timeout;
      logic [7:0]  turn_min_speed;
      logic [7:0]  turn_max_speed;
      logic [7:0]  right_trim;
   } cfg_type;

endpackage

### design/ghdc_csr.sv
// Configuration register file of the heading controller.
// Depends on ghdc_pkg for register indexes and the cfg_type bundle.
module ghdc_csr
   import ghdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_YAW_SCALE:      cfg_in.yaw_scale      = csr_wdata;
            CSR_HEADING_GAIN:   cfg_in.heading_gain   = csr_wdata[11:0];
            CSR_TURN_GAIN:      cfg_in.turn_gain      = csr_wdata[11:0];
            CSR_TURN_TOLERANCE: cfg_in.turn_tolerance = csr_wdata[11:0];
            CSR_TURN_TIMEOUT:   cfg_in.turn_timeout   = csr_wdata;
            CSR_TURN_MIN_SPEED: cfg_in.turn_min_speed = csr_wdata[7:0];
            CSR_TURN_MAX_SPEED: cfg_in.turn_max_speed = csr_wdata[7:0];
            CSR_RIGHT_TRIM:     cfg_in.right_trim     = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_scale      <= 16'd688;
         cfg_ff.heading_gain   <= 12'd640;
         cfg_ff.turn_gain      <= 12'd461;
         cfg_ff.turn_tolerance <= 12'd320;
         cfg_ff.turn_timeout   <= 16'd300;
         cfg_ff.turn_min_speed <= 8'd18;
         cfg_ff.turn_max_speed <= 8'd45;
         cfg_ff.right_trim     <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/ghdc_ctrl.sv
// Sequencer of the heading controller: walks one transaction through the datapath.
// Depends on ghdc_pkg (state_type, cmd_type, request codes) and assert_macros.svh.
`include "assert_macros.svh"
module ghdc_ctrl
   import ghdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_type) inside
                  REQ_TICK:               state_in = ST_YAW_MUL;
                  REQ_STRAIGHT, REQ_TURN: state_in = ST_COMMAND;
                  default:                state_in = ST_RESULT;
               endcase
            end
         end
         ST_YAW_MUL: begin
            cmd.mul_yaw = 1'b1;
            state_in    = ST_YAW_ADD;
         end
         ST_YAW_ADD: begin
            cmd.acc_yaw = 1'b1;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_CORR;
         end
         ST_CORR: begin
            cmd.calc_corr = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_COMMAND: begin
            cmd.apply_cmd = 1'b1;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            // wait here until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != ST_IDLE)
   `ASSERT_IMPLIES(a_load_into_free_slot, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready)

endmodule

### design/ghdc_datapath.sv
// Datapath of the heading controller: yaw integrator, odometers, shared error multiply,
// target update and the output register. Depends on ghdc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ghdc_datapath
   import ghdc_pkg::*;
#(
   parameter int SETTLE_TICKS = 20
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic [1:0]         req_type,
   input  logic signed [17:0] req_gyro_rate,
   input  logic signed [15:0] req_left_count,
   input  logic signed [15:0] req_right_count,
   input  logic signed [10:0] req_drive_speed,
   input  logic signed [15:0] req_turn_angle,
   output logic signed [15:0] rsp_left_target,
   output logic signed [15:0] rsp_right_target,
   output logic signed [31:0] rsp_yaw_now,
   output logic [31:0]        rsp_odometer_left,
   output logic [31:0]        rsp_odometer_right,
   output logic [1:0]         rsp_drive_mode,
   output logic               rsp_turn_ended
);

   localparam logic [15:0] SettleCount = 16'(SETTLE_TICKS);
   localparam bit          SettleNone  = (SETTLE_TICKS == 0);

   function automatic logic signed [15:0] sat16(input logic signed [38:0] v);
      logic signed [15:0] r;
      if (v > 39'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -39'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // captured request
   logic [1:0]         type_ff, type_in;
   logic signed [17:0] gyro_ff, gyro_in;
   logic signed [15:0] lcnt_ff, lcnt_in;
   logic signed [15:0] rcnt_ff, rcnt_in;
   logic signed [10:0] speed_ff, speed_in;
   logic signed [15:0] angle_ff, angle_in;

   // working registers
   logic signed [34:0] yprod_ff, yprod_in;
   logic signed [47:0] err_ff, err_in;
   logic [35:0]        plo_ff, plo_in;
   logic signed [36:0] phi_ff, phi_in;
   logic signed [36:0] corr_ff, corr_in;

   // controller state
   logic signed [47:0] yaw_ff, yaw_in;
   logic signed [47:0] hgoal_ff, hgoal_in;
   logic signed [47:0] tgoal_ff, tgoal_in;
   logic signed [10:0] base_ff, base_in;
   logic [1:0]         mode_ff, mode_in;
   logic [15:0]        tick_ff, tick_in;
   logic [31:0]        odol_ff, odol_in;
   logic [31:0]        odor_ff, odor_in;
   logic signed [15:0] tgtl_ff, tgtl_in;
   logic signed [15:0] tgtr_ff, tgtr_in;
   logic               ended_ff, ended_in;

   // output register
   logic signed [15:0] o_tgtl_ff, o_tgtl_in;
   logic signed [15:0] o_tgtr_ff, o_tgtr_in;
   logic signed [31:0] o_yaw_ff, o_yaw_in;
   logic [31:0]        o_odol_ff, o_odol_in;
   logic [31:0]        o_odor_ff, o_odor_in;
   logic [1:0]         o_mode_ff, o_mode_in;
   logic               o_ended_ff, o_ended_in;

   // combinational terms
   logic signed [17:0] gyro_db;
   logic signed [34:0] yaw_mul;
   logic signed [34:0] yaw_rnd;
   logic signed [28:0] yaw_inc;
   logic signed [47:0] yaw_sum;
   logic [16:0]        l_ext, r_ext, l_abs, r_abs;
   logic               turning;
   logic [11:0]        gain_sel;
   logic signed [47:0] goal_sel;
   logic signed [60:0] prod_full, prod_rnd;
   logic signed [38:0] base_x, corr_x, boost_x;
   logic signed [38:0] str_left, str_right;
   logic [48:0]        err_x, err_mag;
   logic               in_tol, timed_out;
   logic [15:0]        tick_inc;
   logic signed [36:0] s_min, s_max, s_raise, s_clamp;
   logic signed [15:0] s_out;
   logic signed [47:0] yaw_bias_sum;
   logic signed [47:0] turn_sum;

   always_comb begin
      gyro_db = ((gyro_ff > -18'sd32) && (gyro_ff < 18'sd32)) ? 18'sd0 : gyro_ff;
      yaw_mul = gyro_db * $signed({1'b0, cfg.yaw_scale});
      // divide by 64 toward zero
      yaw_rnd = yprod_ff + (yprod_ff[34] ? 35'sd63 : 35'sd0);
      yaw_inc = yaw_rnd[34:6];
      yaw_sum = yaw_ff + {{19{yaw_inc[28]}}, yaw_inc};

      l_ext = {lcnt_ff[15], lcnt_ff};
      r_ext = {rcnt_ff[15], rcnt_ff};
      l_abs = l_ext[16] ? (~l_ext + 17'd1) : l_ext;
      r_abs = r_ext[16] ? (~r_ext + 17'd1) : r_ext;

      turning  = (mode_ff == MODE_TURN);
      gain_sel = turning ? cfg.turn_gain : cfg.heading_gain;
      goal_sel = turning ? tgoal_ff : hgoal_ff;

      // err * gain / 2^24 toward zero, from two 24-bit partial products
      prod_full = $signed({phi_ff, 24'd0}) + $signed({25'd0, plo_ff});
      prod_rnd  = prod_full + (err_ff[47] ? 61'sd16777215 : 61'sd0);

      base_x    = {{28{base_ff[10]}}, base_ff};
      corr_x    = {{2{corr_ff[36]}}, corr_ff};
      boost_x   = {{31{cfg.right_trim[7]}}, cfg.right_trim};
      str_left  = base_x - corr_x;
      str_right = base_x + corr_x + boost_x;

      err_x     = {err_ff[47], err_ff};
      err_mag   = err_x[48] ? (~err_x + 49'd1) : err_x;
      in_tol    = err_mag < {27'd0, cfg.turn_tolerance, 10'd0};
      tick_inc  = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
      timed_out = tick_inc > cfg.turn_timeout;

      // minimum applies first, maximum wins
      s_min = $signed({29'd0, cfg.turn_min_speed});
      s_max = $signed({29'd0, cfg.turn_max_speed});
      if ((corr_ff > 37'sd0) && (corr_ff < s_min)) begin
         s_raise = s_min;
      end else if ((corr_ff < 37'sd0) && (corr_ff > -s_min)) begin
         s_raise = -s_min;
      end else begin
         s_raise = corr_ff;
      end
      if (s_raise > s_max) begin
         s_clamp = s_max;
      end else if (s_raise < -s_max) begin
         s_clamp = -s_max;
      end else begin
         s_clamp = s_raise;
      end
      s_out = s_clamp[15:0];

      yaw_bias_sum = yaw_ff + (yaw_ff[47] ? 48'sd1023 : 48'sd0);
      turn_sum     = yaw_ff + {{22{angle_ff[15]}}, angle_ff, 10'd0};
   end

   always_comb begin
      type_in    = type_ff;
      gyro_in    = gyro_ff;
      lcnt_in    = lcnt_ff;
      rcnt_in    = rcnt_ff;
      speed_in   = speed_ff;
      angle_in   = angle_ff;
      yprod_in   = yprod_ff;
      err_in     = err_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;
      corr_in    = corr_ff;
      yaw_in     = yaw_ff;
      hgoal_in   = hgoal_ff;
      tgoal_in   = tgoal_ff;
      base_in    = base_ff;
      mode_in    = mode_ff;
      tick_in    = tick_ff;
      odol_in    = odol_ff;
      odor_in    = odor_ff;
      tgtl_in    = tgtl_ff;
      tgtr_in    = tgtr_ff;
      ended_in   = ended_ff;
      o_tgtl_in  = o_tgtl_ff;
      o_tgtr_in  = o_tgtr_ff;
      o_yaw_in   = o_yaw_ff;
      o_odol_in  = o_odol_ff;
      o_odor_in  = o_odor_ff;
      o_mode_in  = o_mode_ff;
      o_ended_in = o_ended_ff;

      if (cmd.capture) begin
         type_in  = req_type;
         gyro_in  = req_gyro_rate;
         lcnt_in  = req_left_count;
         rcnt_in  = req_right_count;
         speed_in = req_drive_speed;
         angle_in = req_turn_angle;
         ended_in = 1'b0;
      end

      if (cmd.mul_yaw) begin
         yprod_in = yaw_mul;
      end

      if (cmd.acc_yaw) begin
         yaw_in  = yaw_sum;
         odol_in = odol_ff + {15'd0, l_abs};
         odor_in = odor_ff + {15'd0, r_abs};
      end

      if (cmd.calc_err) begin
         err_in = goal_sel - yaw_ff;
      end

      if (cmd.mul_lo) begin
         plo_in = 36'(err_ff[23:0]) * 36'(gain_sel);
      end

      if (cmd.mul_hi) begin
         phi_in = $signed(err_ff[47:24]) * $signed({1'b0, gain_sel});
      end

      if (cmd.calc_corr) begin
         corr_in = prod_rnd[60:24];
      end

      if (cmd.update) begin
         case (mode_ff)
            MODE_TURN: begin
               tick_in = tick_inc;
               if (in_tol || timed_out) begin
                  tgtl_in  = 16'sd0;
                  tgtr_in  = 16'sd0;
                  ended_in = 1'b1;
                  mode_in  = MODE_SETTLE;
                  tick_in  = 16'd0;
                  if (SettleNone) begin
                     hgoal_in = yaw_ff;
                     mode_in  = MODE_STRAIGHT;
                  end
               end else begin
                  tgtl_in = -s_out;
                  tgtr_in = s_out;
               end
            end
            MODE_SETTLE: begin
               tgtl_in = 16'sd0;
               tgtr_in = 16'sd0;
               tick_in = tick_inc;
               if (tick_inc >= SettleCount) begin
                  hgoal_in = yaw_ff;
                  mode_in  = MODE_STRAIGHT;
               end
            end
            MODE_STRAIGHT: begin
               if (base_ff == 11'sd0) begin
                  tgtl_in = 16'sd0;
                  tgtr_in = 16'sd0;
               end else begin
                  tgtl_in = sat16(str_left);
                  tgtr_in = sat16(str_right);
               end
            end
            default: mode_in = mode_ff;
         endcase
      end

      if (cmd.apply_cmd) begin
         if (type_ff == REQ_STRAIGHT) begin
            base_in  = speed_ff;
            hgoal_in = yaw_ff;
            mode_in  = MODE_STRAIGHT;
         end else if (type_ff == REQ_TURN) begin
            tgoal_in = turn_sum;
            base_in  = 11'sd0;
            tick_in  = 16'd0;
            mode_in  = MODE_TURN;
         end
      end

      if (cmd.load_rsp) begin
         o_tgtl_in  = tgtl_ff;
         o_tgtr_in  = tgtr_ff;
         o_yaw_in   = yaw_bias_sum[41:10];
         o_odol_in  = odol_ff;
         o_odor_in  = odor_ff;
         o_mode_in  = mode_ff;
         o_ended_in = ended_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff     <= '0;
         hgoal_ff   <= '0;
         tgoal_ff   <= '0;
         base_ff    <= '0;
         mode_ff    <= MODE_STRAIGHT;
         tick_ff    <= '0;
         odol_ff    <= '0;
         odor_ff    <= '0;
         tgtl_ff    <= '0;
         tgtr_ff    <= '0;
         ended_ff   <= 1'b0;
         o_mode_ff  <= MODE_STRAIGHT;
         o_ended_ff <= 1'b0;
      end else begin
         yaw_ff     <= yaw_in;
         hgoal_ff   <= hgoal_in;
         tgoal_ff   <= tgoal_in;
         base_ff    <= base_in;
         mode_ff    <= mode_in;
         tick_ff    <= tick_in;
         odol_ff    <= odol_in;
         odor_ff    <= odor_in;
         tgtl_ff    <= tgtl_in;
         tgtr_ff    <= tgtr_in;
         ended_ff   <= ended_in;
         o_mode_ff  <= o_mode_in;
         o_ended_ff <= o_ended_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      gyro_ff   <= gyro_in;
      lcnt_ff   <= lcnt_in;
      rcnt_ff   <= rcnt_in;
      speed_ff  <= speed_in;
      angle_ff  <= angle_in;
      yprod_ff  <= yprod_in;
      err_ff    <= err_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      corr_ff   <= corr_in;
      o_tgtl_ff <= o_tgtl_in;
      o_tgtr_ff <= o_tgtr_in;
      o_yaw_ff  <= o_yaw_in;
      o_odol_ff <= o_odol_in;
      o_odor_ff <= o_odor_in;
   end

   assign rsp_left_target    = o_tgtl_ff;
   assign rsp_right_target   = o_tgtr_ff;
   assign rsp_yaw_now        = o_yaw_ff;
   assign rsp_odometer_left  = o_odol_ff;
   assign rsp_odometer_right = o_odor_ff;
   assign rsp_drive_mode     = o_mode_ff;
   assign rsp_turn_ended     = o_ended_ff;

   `ASSERT_IMPLIES(a_ended_left_turn, clock, reset, ended_ff, mode_ff != MODE_TURN)
   `ASSERT_IMPLIES(a_rsp_ended_mode, clock, reset, o_ended_ff, o_mode_ff != MODE_TURN)

endmodule

### design/gyro_heading_drive_controller_top.sv
// Gyro heading drive controller, top level: config registers, sequencer, datapath.
// A tick transaction walks the sequencer through yaw multiply, yaw add, error, two partial
//   products, correction, update and result; a straight or turn command through command and
//   result; any other code goes straight to result. Result waits until the output register is
//   free, and a new request is taken only in idle, once the previous one has been loaded.
// Reset: synchronous, active high; registers return to defaults, state clears, mode straight.
module gyro_heading_drive_controller_top
   import ghdc_pkg::*;
#(
   parameter int SETTLE_TICKS = 20
)
(
   input  logic               clock,
   input  logic               reset,
   // configuration write port
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [17:0] req_gyro_rate,
   input  logic signed [15:0] req_left_count,
   input  logic signed [15:0] req_right_count,
   input  logic signed [10:0] req_drive_speed,
   input  logic signed [15:0] req_turn_angle,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_left_target,
   output logic signed [15:0] rsp_right_target,
   output logic signed [31:0] rsp_yaw_now,
   output logic [31:0]        rsp_odometer_left,
   output logic [31:0]        rsp_odometer_right,
   output logic [1:0]         rsp_drive_mode,
   output logic               rsp_turn_ended
);

   cfg_type cfg;
   cmd_type cmd;

   // Register file; a write takes effect at once, so the host writes only while no
   // transaction is in flight.
   ghdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: takes a transaction in idle, steps the datapath, then loads the
   // output register once the previous response has been taken.
   ghdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: yaw integration, odometers, heading/turn error times gain (48x12
   // product split in two 24-bit halves), target saturation, mode tracking.
   ghdc_datapath #(
      .SETTLE_TICKS (SETTLE_TICKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_type           (req_type),
      .req_gyro_rate      (req_gyro_rate),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .req_drive_speed    (req_drive_speed),
      .req_turn_angle     (req_turn_angle),
      .rsp_left_target    (rsp_left_target),
      .rsp_right_target   (rsp_right_target),
      .rsp_yaw_now        (rsp_yaw_now),
      .rsp_odometer_left  (rsp_odometer_left),
      .rsp_odometer_right (rsp_odometer_right),
      .rsp_drive_mode     (rsp_drive_mode),
      .rsp_turn_ended     (rsp_turn_ended)
   );

endmodule
